// File: design/simple9_stream_packer_defines.svh
// ----------------------------------------------------------------------------
// Simple-9 stream packer assertion macros
// Shared concurrent assertion forms, clocked on aclk and gated by reset.
// ----------------------------------------------------------------------------
`ifndef SIMPLE9_STREAM_PACKER_DEFINES_SVH
`define SIMPLE9_STREAM_PACKER_DEFINES_SVH

// Same-cycle implication: the property argument holds an |-> expression.
`define S9SP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Next-cycle implication built from an antecedent and a consequent.
`define S9SP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/s9sp_pkg.sv
// ----------------------------------------------------------------------------
// s9sp_pkg
// Constants, selector table and shared types of the Simple-9 stream packer.
// ----------------------------------------------------------------------------
package s9sp_pkg;

    localparam int MAX_PER_WORD  = 28;
    localparam int SELECTOR_BITS = 4;
    localparam int NUM_ROWS      = 9;
    localparam int VALUE_BITS    = 28;
    localparam int WORD_BITS     = 32;
    localparam int ROW_W         = 4;
    localparam int CNT_W         = 5;
    localparam int POS_W         = 6;

    // Values per word for each selector row.
    function automatic logic [CNT_W-1:0] row_count(input logic [ROW_W-1:0] row);
        logic [CNT_W-1:0] c;
        case (row)
            4'd0:    c = 5'd28;
            4'd1:    c = 5'd14;
            4'd2:    c = 5'd9;
            4'd3:    c = 5'd7;
            4'd4:    c = 5'd5;
            4'd5:    c = 5'd4;
            4'd6:    c = 5'd3;
            4'd7:    c = 5'd2;
            default: c = 5'd1;
        endcase
        return c;
    endfunction

    // Bits per value for each selector row.
    function automatic logic [CNT_W-1:0] row_bits(input logic [ROW_W-1:0] row);
        logic [CNT_W-1:0] b;
        case (row)
            4'd0:    b = 5'd1;
            4'd1:    b = 5'd2;
            4'd2:    b = 5'd3;
            4'd3:    b = 5'd4;
            4'd4:    b = 5'd5;
            4'd5:    b = 5'd7;
            4'd6:    b = 5'd9;
            4'd7:    b = 5'd14;
            default: b = 5'd28;
        endcase
        return b;
    endfunction

    // First row whose slot width holds this value on its own.
    function automatic logic [ROW_W-1:0] row_class(input logic [VALUE_BITS-1:0] v);
        logic [ROW_W-1:0] cls;
        logic             found;
        cls   = ROW_W'(NUM_ROWS - 1);
        found = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (!found && ((v >> row_bits(ROW_W'(r))) == '0)) begin
                cls   = ROW_W'(r);
                found = 1'b1;
            end
        end
        return cls;
    endfunction

    typedef struct packed {
        logic                  append;
        logic                  shift;
        logic [VALUE_BITS-1:0] value;
        logic [ROW_W-1:0]      row;
    } buf_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0]      count;
        logic [CNT_W-1:0]      take;
        logic                  fits;
        logic [VALUE_BITS-1:0] head;
    } buf_stat_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [CNT_W-1:0]     n;
        logic                 err;
        logic                 last;
    } result_t;

endpackage

// File: design/s9sp_buffer.sv
// ----------------------------------------------------------------------------
// s9sp_buffer
// Pending value line with per-entry row class and the shared fit compare.
// ----------------------------------------------------------------------------
module s9sp_buffer (
    input  logic                aclk,
    input  logic                aresetn,
    input  s9sp_pkg::buf_ctrl_t ctrl,
    output s9sp_pkg::buf_stat_t stat
);

    logic [s9sp_pkg::VALUE_BITS-1:0] vals_reg [s9sp_pkg::MAX_PER_WORD];
    logic [s9sp_pkg::ROW_W-1:0]      cls_reg  [s9sp_pkg::MAX_PER_WORD];
    logic [s9sp_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [s9sp_pkg::CNT_W-1:0]      cap, take;
    logic                            fits;

    always_comb begin
        count_next = count_reg;
        if (ctrl.append) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.shift) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.append) begin
            vals_reg[count_reg] <= ctrl.value;
            cls_reg[count_reg]  <= s9sp_pkg::row_class(ctrl.value);
        end else if (ctrl.shift) begin
            // advance the line by one entry toward the head
            for (int i = 0; i < s9sp_pkg::MAX_PER_WORD - 1; i++) begin
                vals_reg[i] <= vals_reg[i+1];
                cls_reg[i]  <= cls_reg[i+1];
            end
        end
    end

    // Row fits when every entry it would take has a class at or below it.
    always_comb begin
        cap  = s9sp_pkg::row_count(ctrl.row);
        take = (count_reg < cap) ? count_reg : cap;
        fits = 1'b1;
        for (int i = 0; i < s9sp_pkg::MAX_PER_WORD; i++) begin
            if ((s9sp_pkg::CNT_W'(i) < take) && (cls_reg[i] > ctrl.row)) begin
                fits = 1'b0;
            end
        end
    end

    assign stat.count = count_reg;
    assign stat.take  = take;
    assign stat.fits  = fits;
    assign stat.head  = vals_reg[0];

endmodule

// File: design/s9sp_packer.sv
// ----------------------------------------------------------------------------
// s9sp_packer
// Sequencer: selector search one row a cycle, then shift-or one value a cycle.
// ----------------------------------------------------------------------------
module s9sp_packer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [s9sp_pkg::WORD_BITS-1:0]    s_value,
    input  logic                              s_end_of_stream,
    input  s9sp_pkg::buf_stat_t               stat,
    output s9sp_pkg::buf_ctrl_t               ctrl,
    output logic                              res_valid,
    input  logic                              res_free,
    output s9sp_pkg::result_t                 res
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ERR    = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_PACK   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]                       state_reg, state_next;
    logic                             flush_reg, flush_next;
    logic                             eos_reg, eos_next;
    logic [s9sp_pkg::ROW_W-1:0]       row_reg, row_next;
    logic [s9sp_pkg::CNT_W-1:0]       left_reg, left_next;
    logic [s9sp_pkg::CNT_W-1:0]       n_reg, n_next;
    logic [s9sp_pkg::WORD_BITS-1:0]   word_reg, word_next;
    logic [s9sp_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic                             accept, oversize;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign oversize = |s_value[s9sp_pkg::WORD_BITS-1:s9sp_pkg::VALUE_BITS];

    always_comb begin
        state_next  = state_reg;
        flush_next  = flush_reg;
        eos_next    = eos_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        n_next      = n_reg;
        word_next   = word_reg;
        pos_next    = pos_reg;
        ctrl.append = 1'b0;
        ctrl.shift  = 1'b0;
        ctrl.value  = s_value[s9sp_pkg::VALUE_BITS-1:0];
        ctrl.row    = row_reg;
        res_valid   = 1'b0;
        res.word    = word_reg;
        res.n       = n_reg;
        res.err     = 1'b0;
        res.last    = !flush_reg || (stat.count == '0);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    row_next = '0;
                    if (oversize) begin
                        eos_next   = s_end_of_stream;
                        state_next = ST_ERR;
                    end else begin
                        ctrl.append = 1'b1;
                        flush_next  = s_end_of_stream;
                        if (s_end_of_stream ||
                            (stat.count == s9sp_pkg::CNT_W'(s9sp_pkg::MAX_PER_WORD - 1))) begin
                            state_next = ST_SEARCH;
                        end
                    end
                end
            end
            ST_ERR: begin
                res_valid = 1'b1;
                res.word  = '0;
                res.n     = '0;
                res.err   = 1'b1;
                res.last  = !eos_reg || (stat.count == '0);
                if (res_free) begin
                    flush_next = eos_reg;
                    if (eos_reg && (stat.count != '0)) begin
                        state_next = ST_SEARCH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SEARCH: begin
                if (stat.fits || (row_reg == s9sp_pkg::ROW_W'(s9sp_pkg::NUM_ROWS - 1))) begin
                    left_next  = stat.take;
                    n_next     = stat.take;
                    word_next  = s9sp_pkg::WORD_BITS'(row_reg);
                    pos_next   = s9sp_pkg::POS_W'(s9sp_pkg::SELECTOR_BITS);
                    state_next = ST_PACK;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end
            ST_PACK: begin
                // drop the head value into its slot and advance the line
                ctrl.shift = 1'b1;
                word_next  = word_reg |
                             ({{(s9sp_pkg::WORD_BITS - s9sp_pkg::VALUE_BITS){1'b0}},
                               stat.head} << pos_reg);
                pos_next   = pos_reg + s9sp_pkg::POS_W'(s9sp_pkg::row_bits(row_reg));
                left_next  = left_reg - 1'b1;
                if (left_reg == s9sp_pkg::CNT_W'(1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                res_valid = 1'b1;
                if (res_free) begin
                    row_next = '0;
                    if (flush_reg && (stat.count != '0)) begin
                        state_next = ST_SEARCH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            flush_reg <= 1'b0;
            eos_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            flush_reg <= flush_next;
            eos_reg   <= eos_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg  <= row_next;
        left_reg <= left_next;
        n_reg    <= n_next;
        word_reg <= word_next;
        pos_reg  <= pos_next;
    end

endmodule

// File: design/simple9_stream_packer.sv
// A value that fills no word keeps the packer idle; one value per cycle follows while idle.
// A packed word goes through selector search, one row per cycle in the
// shared fit compare, then the shift-or unit, one packed value at a time, then the
// output register once it is free; a flush repeats this for every word it needs.
// An oversize value passes through the error state to the output register as its error word.
// Reset (aresetn low, synchronous) empties the buffer and drops any pending output word.
// ----------------------------------------------------------------------------
// simple9_stream_packer
// Buffers unsigned values and packs them into 32-bit Simple-9 words.
// ----------------------------------------------------------------------------
module simple9_stream_packer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value,
    input  logic        s_end_of_stream,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_packed_word,
    output logic [4:0]  m_values_packed,
    output logic        m_oversize_error,
    output logic        m_last_of_run
);

    s9sp_pkg::buf_ctrl_t ctrl;
    s9sp_pkg::buf_stat_t stat;
    s9sp_pkg::result_t   res;
    s9sp_pkg::result_t   out_reg;
    logic                res_valid;
    logic                res_free;
    logic                m_valid_reg, m_valid_next;

    s9sp_buffer u_buffer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .stat    (stat)
    );

    s9sp_packer u_packer (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value         (s_value),
        .s_end_of_stream (s_end_of_stream),
        .stat            (stat),
        .ctrl            (ctrl),
        .res_valid       (res_valid),
        .res_free        (res_free),
        .res             (res)
    );

    // Output word register: free when empty or being taken this cycle.
    assign res_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_free) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_free && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_packed_word    = out_reg.word;
    assign m_values_packed  = out_reg.n;
    assign m_oversize_error = out_reg.err;
    assign m_last_of_run    = out_reg.last;

endmodule

// File: design/s9sp_checker.sv
// ----------------------------------------------------------------------------
// s9sp_checker
// Port-level checks of the Simple-9 stream packer, bound to the top level.
// ----------------------------------------------------------------------------
`include "simple9_stream_packer_defines.svh"

module s9sp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [31:0] s_value,
    input logic        s_end_of_stream,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_packed_word,
    input logic [4:0]  m_values_packed,
    input logic        m_oversize_error,
    input logic        m_last_of_run
);

    // hold a stalled output word
    `S9SP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_packed_word), "stalled output word changed")

    `S9SP_ASSERT(a_err_empty, m_valid && m_oversize_error |-> m_values_packed == 5'd0 && m_packed_word == 32'd0, "error word carries data")

    `S9SP_ASSERT(a_count_range, m_valid && !m_oversize_error |-> m_values_packed != 5'd0 && m_values_packed <= 5'd28, "packed count out of range")

    // a full 28-value word can only use the one-bit row
    `S9SP_ASSERT(a_full_sel, m_valid && m_values_packed == 5'd28 |-> m_packed_word[3:0] == 4'd0, "full word with wrong selector")

    // an oversize value taken without end of stream holds off the input for its error word
    `S9SP_ASSERT_NEXT(a_err_single, s_valid && s_ready && (s_value[31:28] != 4'd0) && !s_end_of_stream, !s_ready, "busy flag missing after oversize value")

endmodule

bind simple9_stream_packer s9sp_checker u_s9sp_checker (.*);

// File: sim/simple9_word_checker.sv
// ----------------------------------------------------------------------------
// Simple-9 word checker
// Watches both channels of the stream packer and keeps its own copy of the
// value buffer. It predicts each packed word and error word from the
// accepted values, then compares every delivered word field by field.
// ----------------------------------------------------------------------------
module simple9_word_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_value,
    input  logic        s_end_of_stream,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_packed_word,
    input  logic [4:0]  m_values_packed,
    input  logic        m_oversize_error,
    input  logic        m_last_of_run,
    output int          fail_count,
    output int          words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // Values per word for each selector, selector 0 in the low slot.
    localparam logic [s9sp_pkg::NUM_ROWS-1:0][s9sp_pkg::CNT_W-1:0] ROW_COUNT =
        {5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd7, 5'd9, 5'd14, 5'd28};
    localparam logic [31:0] VALUE_LIMIT = 32'h0FFF_FFFF;

    logic [s9sp_pkg::VALUE_BITS-1:0] held [s9sp_pkg::MAX_PER_WORD];
    int                              held_count;
    s9sp_pkg::result_t               due_q [$];
    s9sp_pkg::result_t               want;

    // Pack one word from the front of the buffer and drop the values it holds.
    function automatic s9sp_pkg::result_t pack_front();
        int                row;
        int                take;
        int                bits;
        logic              found;
        logic              fits;
        s9sp_pkg::result_t w;
        found = 1'b0;
        row   = s9sp_pkg::NUM_ROWS - 1;
        for (int r = 0; r < s9sp_pkg::NUM_ROWS; r++) begin
            if (!found) begin
                take = (ROW_COUNT[r] > held_count) ? held_count : int'(ROW_COUNT[r]);
                bits = s9sp_pkg::VALUE_BITS / ROW_COUNT[r];
                fits = 1'b1;
                for (int i = 0; i < take; i++) begin
                    if ((held[i] >> bits) != '0)
                        fits = 1'b0;
                end
                if (fits) begin
                    found = 1'b1;
                    row   = r;
                end
            end
        end
        take = (ROW_COUNT[row] > held_count) ? held_count : int'(ROW_COUNT[row]);
        bits = s9sp_pkg::VALUE_BITS / ROW_COUNT[row];
        w.word = 32'(row);
        for (int i = 0; i < take; i++)
            w.word = w.word | (32'(held[i]) << (s9sp_pkg::SELECTOR_BITS + i * bits));
        for (int i = 0; i < held_count - take; i++)
            held[i] = held[i + take];
        held_count = held_count - take;
        w.n    = s9sp_pkg::CNT_W'(take);
        w.err  = 1'b0;
        w.last = 1'b0;
        return w;
    endfunction

    function automatic void predict_words(input logic [31:0] v, input logic eos);
        s9sp_pkg::result_t run [$];
        s9sp_pkg::result_t w;
        if (held_count > s9sp_pkg::MAX_PER_WORD)
            held_count = s9sp_pkg::MAX_PER_WORD;
        if (v > VALUE_LIMIT) begin
            w.word = '0;
            w.n    = '0;
            w.err  = 1'b1;
            w.last = 1'b0;
            run.push_back(w);
        end else begin
            if (held_count >= s9sp_pkg::MAX_PER_WORD)
                run.push_back(pack_front());
            held[held_count] = v[s9sp_pkg::VALUE_BITS-1:0];
            held_count++;
            if (!eos && held_count >= s9sp_pkg::MAX_PER_WORD)
                run.push_back(pack_front());
        end
        if (eos) begin
            while (held_count > 0 && run.size() < s9sp_pkg::MAX_PER_WORD)
                run.push_back(pack_front());
        end
        if (run.size() > 0) begin
            w      = run[run.size() - 1];
            w.last = 1'b1;
            run[run.size() - 1] = w;
        end
        foreach (run[i])
            due_q.push_back(run[i]);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_count = 0;
            due_q.delete();
        end else begin
            if (s_valid && s_ready)
                predict_words(s_value, s_end_of_stream);
            if (m_valid && m_ready) begin
                if (due_q.size() == 0) begin
                    $error("unexpected word: packed_word %h values_packed %0d",
                           m_packed_word, m_values_packed);
                    fail_count++;
                end else begin
                    want = due_q.pop_front();
                    if (m_packed_word !== want.word) begin
                        $error("packed_word: expected %h, actual %h",
                               want.word, m_packed_word);
                        fail_count++;
                    end
                    if (m_values_packed !== want.n) begin
                        $error("values_packed: expected %0d, actual %0d",
                               want.n, m_values_packed);
                        fail_count++;
                    end
                    if (m_oversize_error !== want.err) begin
                        $error("oversize_error: expected %b, actual %b",
                               want.err, m_oversize_error);
                        fail_count++;
                    end
                    if (m_last_of_run !== want.last) begin
                        $error("last_of_run: expected %b, actual %b",
                               want.last, m_last_of_run);
                        fail_count++;
                    end
                end
            end
        end
        words_due <= due_q.size();
    end

endmodule

// File: sim/tb_simple9_stream_packer.sv
// ----------------------------------------------------------------------------
// Simple-9 stream packer testbench
// Drives directed values and random streams of mixed widths through the
// packer under several idle and stall patterns; a checker beside the block
// predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_simple9_stream_packer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 50;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [31:0] s_value         = '0;
    logic        s_end_of_stream = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [31:0] m_packed_word;
    logic [4:0]  m_values_packed;
    logic        m_oversize_error;
    logic        m_last_of_run;

    int fail_count;
    int words_due;
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;

    always #6 aclk = ~aclk;

    simple9_stream_packer uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_value          (s_value),
        .s_end_of_stream  (s_end_of_stream),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_packed_word    (m_packed_word),
        .m_values_packed  (m_values_packed),
        .m_oversize_error (m_oversize_error),
        .m_last_of_run    (m_last_of_run)
    );

    simple9_word_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_value          (s_value),
        .s_end_of_stream  (s_end_of_stream),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_packed_word    (m_packed_word),
        .m_values_packed  (m_values_packed),
        .m_oversize_error (m_oversize_error),
        .m_last_of_run    (m_last_of_run),
        .fail_count       (fail_count),
        .words_due        (words_due)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one value; hold valid and payload until the value is taken.
    task automatic send_value(input logic [31:0] v, input logic eos);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_value         <= v;
        s_end_of_stream <= eos;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Hold the sender off until every predicted word has been delivered.
    task automatic wait_drained(input int settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_due != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    function automatic logic [31:0] oversize_value();
        logic [31:0] v;
        v = $urandom;
        if (v[31:28] == 4'd0)
            v[28 + $urandom_range(3)] = 1'b1;
        return v;
    endfunction

    function automatic logic [31:0] bounded_value(input int cap);
        int          w;
        logic [31:0] v;
        w = $urandom_range(cap);
        if (w == 0)
            v = '0;
        else
            v = ($urandom & ((32'h1 << w) - 1)) | (32'h1 << (w - 1));
        return v;
    endfunction

    task automatic run_streams(input int n_values);
        int          sent;
        int          len;
        int          cap;
        int          pick;
        logic [31:0] v;
        sent = 0;
        while (sent < n_values) begin
            pick = $urandom_range(9);
            if (pick < 6)
                len = $urandom_range(12, 1);
            else if (pick < 8)
                len = $urandom_range(40, 26);
            else
                len = 28 + $urandom_range(1);
            // Trim the last stream so the phase sends exactly its share.
            if (len > n_values - sent)
                len = n_values - sent;
            // Narrow caps let long runs of tiny values fill dense words.
            case ($urandom_range(8))
                0:       cap = 1;
                1:       cap = 2;
                2:       cap = 3;
                3:       cap = 4;
                4:       cap = 5;
                5:       cap = 7;
                6:       cap = 9;
                7:       cap = 14;
                default: cap = 28;
            endcase
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(19) == 0)
                    v = oversize_value();
                else if ($urandom_range(7) == 0)
                    v = bounded_value(28);
                else
                    v = bounded_value(cap);
                send_value(v, i == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single zero, then an oversize value with nothing buffered, then the largest legal value.
        send_value(32'h0000_0000, 1'b1);
        send_value(32'hFFFF_FFFF, 1'b1);
        send_value(32'h0FFF_FFFF, 1'b1);
        // Mixed widths with an oversize value mid-stream, then a flush
        // behind an oversize final value.
        send_value(32'd1, 1'b0);
        send_value(32'd3, 1'b0);
        send_value(32'd7, 1'b0);
        send_value(32'h1000_0000, 1'b0);
        send_value(32'd15, 1'b0);
        send_value(32'd31, 1'b0);
        send_value(32'd127, 1'b0);
        send_value(32'd511, 1'b0);
        send_value(32'd16383, 1'b0);
        send_value(32'h0ABC_DEF1, 1'b0);
        send_value(32'h8000_0000, 1'b1);
        // Short flush with unused slots, then an oversize value and a single-value flush.
        send_value(32'd2, 1'b0);
        send_value(32'd5, 1'b1);
        send_value(32'hF000_0000, 1'b0);
        send_value(32'd1, 1'b1);
        wait_drained(SETTLE);

        idle_pct = 0;
        stall_pct <= 0;
        run_streams(35);
        wait_drained(SETTLE);

        idle_pct = 82;
        stall_pct <= 0;
        run_streams(35);
        wait_drained(SETTLE);

        idle_pct = 0;
        stall_pct <= 82;
        run_streams(35);
        wait_drained(SETTLE);

        idle_pct = 11;
        stall_pct <= 11;
        run_streams(35);
        wait_drained(100);

        if (fail_count == 0 && words_due == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: simple9_stream_packer.f
+incdir+design
design/s9sp_pkg.sv
design/s9sp_buffer.sv
design/s9sp_packer.sv
design/simple9_stream_packer.sv
design/s9sp_checker.sv
sim/simple9_word_checker.sv
sim/tb_simple9_stream_packer.sv
